### hw/rtl/tun_pkg.sv
// Shared types and widths for the triangle unit normal block.
// No dependencies; imported by every module of the block.
`default_nettype none
package tun_pkg;
  localparam int CoordW = 32;             // coordinate width
  localparam int EdgeW  = CoordW + 1;     // edge vector component
  localparam int ProdW  = 2 * EdgeW;      // one product of edge components
  localparam int CrossW = ProdW + 1;      // cross component magnitude
  localparam int HalfW  = (CrossW + 1) / 2;
  localparam int SumW   = 2 * CrossW + 2; // sum of three squares
  localparam int LenW   = SumW / 2;       // length from the square root
  localparam int RemW   = LenW + 2;
  localparam int QuotW  = 31;             // quotient bits, up to 2^30
  localparam int OutW   = 32;
  localparam logic [OutW-1:0] OneQ30 = OutW'(32'h4000_0000);
  localparam int FifoDepth = 4;
  localparam int FifoAw    = 2;

  // One classified word passed from the front part to the back part.
  typedef struct packed {
    logic [2:0][CrossW-1:0] mag;
    logic [2:0]             neg;
    logic                   degen;
  } cross_word_t;
endpackage
`default_nettype wire

### hw/rtl/tun_front.sv
// Front part: edge vectors, exact cross product, sign/magnitude split.
// Depends on tun_pkg.
`default_nettype none
module tun_front
  import tun_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [CoordW-1:0] in_ax, in_ay, in_az,
  input  wire logic [CoordW-1:0] in_bx, in_by, in_bz,
  input  wire logic [CoordW-1:0] in_cx, in_cy, in_cz,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output cross_word_t            push_word
);
  logic v1_r, v2_r, v3_r, adv;
  logic signed [EdgeW-1:0] e1_r [3];
  logic signed [EdgeW-1:0] e2_r [3];
  logic signed [ProdW-1:0] p_r [3];
  logic signed [ProdW-1:0] q_r [3];
  cross_word_t word_r, word_nxt;

  // The whole pipe moves when its last stage is empty or drains.
  assign adv        = !v3_r || push_ready;
  assign in_ready   = adv;
  assign push_valid = v3_r;
  assign push_word  = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Stage one: edges taken from the first vertex.
  always_ff @(posedge clk) begin
    if (adv) begin
      e1_r[0] <= $signed({in_bx[CoordW-1], in_bx}) - $signed({in_ax[CoordW-1], in_ax});
      e1_r[1] <= $signed({in_by[CoordW-1], in_by}) - $signed({in_ay[CoordW-1], in_ay});
      e1_r[2] <= $signed({in_bz[CoordW-1], in_bz}) - $signed({in_az[CoordW-1], in_az});
      e2_r[0] <= $signed({in_cx[CoordW-1], in_cx}) - $signed({in_ax[CoordW-1], in_ax});
      e2_r[1] <= $signed({in_cy[CoordW-1], in_cy}) - $signed({in_ay[CoordW-1], in_ay});
      e2_r[2] <= $signed({in_cz[CoordW-1], in_cz}) - $signed({in_az[CoordW-1], in_az});
    end
  end

  // Stage two: the six products of the cross product.
  always_ff @(posedge clk) begin
    if (adv) begin
      p_r[0] <= e1_r[1] * e2_r[2];
      q_r[0] <= e2_r[1] * e1_r[2];
      p_r[1] <= e2_r[0] * e1_r[2];
      q_r[1] <= e1_r[0] * e2_r[2];
      p_r[2] <= e1_r[0] * e2_r[1];
      q_r[2] <= e2_r[0] * e1_r[1];
    end
  end

  // Stage three: differences, split into sign and magnitude.
  always_comb begin
    logic signed [CrossW-1:0] c;
    word_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      c = CrossW'(p_r[k]) - CrossW'(q_r[k]);
      word_nxt.neg[k] = c[CrossW-1];
      word_nxt.mag[k] = c[CrossW-1] ? CrossW'(-c) : CrossW'(c);
    end
    word_nxt.degen = (word_nxt.mag == '0);
  end

  always_ff @(posedge clk) begin
    if (adv) word_r <= word_nxt;
  end
endmodule
`default_nettype wire

### hw/rtl/tun_fifo.sv
// Short queue of classified words between the front and back parts.
// Depends on tun_pkg.
`default_nettype none
module tun_fifo
  import tun_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        wr_valid,
  output logic             wr_ready,
  input  wire cross_word_t wr_word,
  output logic             rd_valid,
  input  wire logic        rd_pop,
  output cross_word_t      rd_word
);
  cross_word_t mem_r [FifoDepth];
  logic [FifoAw-1:0] wp_r, rp_r;
  logic [FifoAw:0]   cnt_r;
  logic do_wr, do_rd;

  assign wr_ready = (cnt_r != (FifoAw+1)'(FifoDepth));
  assign rd_valid = (cnt_r != '0);
  assign rd_word  = mem_r[rp_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  // Storage writes.
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_word;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= wp_r + 1'b1;
      if (do_rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (FifoAw+1)'(do_wr) - (FifoAw+1)'(do_rd);
    end
  end
endmodule
`default_nettype wire

### hw/rtl/tun_back.sv
// Back part: sum of squares, bit-serial square root, three dividers, result register.
// Depends on tun_pkg.
`default_nettype none
module tun_back
  import tun_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        rd_valid,
  output logic             rd_pop,
  input  wire cross_word_t rd_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [OutW-1:0]  out_nx,
  output logic [OutW-1:0]  out_ny,
  output logic [OutW-1:0]  out_nz,
  output logic             out_degenerate
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSq   = 3'd1;
  localparam logic [2:0] StSqrt = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0] st_r;
  logic [6:0] cnt_r;
  logic [1:0] k_r, part_r, shsel_r;
  logic       acc_en_r;
  cross_word_t w_r;
  logic [2*HalfW-1:0] prod_r;
  logic [SumW-1:0]    sum_r;
  logic [RemW-1:0]    srem_r;
  logic [LenW-1:0]    root_r;
  logic [RemW-1:0]    drem_r [3];
  logic [QuotW-1:0]   q_r [3];
  logic               out_valid_r;
  logic [OutW-1:0]    nx_r, ny_r, nz_r;
  logic               dg_r;

  logic [HalfW-1:0] opa, opb;
  logic [CrossW-1:0] msel;
  logic [SumW-1:0]  addend;
  logic [RemW-1:0]  srem_nxt, trial;
  logic             take_out;

  assign out_valid      = out_valid_r;
  assign out_nx         = nx_r;
  assign out_ny         = ny_r;
  assign out_nz         = nz_r;
  assign out_degenerate = dg_r;
  assign rd_pop         = (st_r == StIdle);
  assign take_out       = !out_valid_r || out_ready;

  // Operand select for the squares: low*low, low*high (doubled), high*high.
  always_comb begin
    case (k_r)
      2'd0:    msel = w_r.mag[0];
      2'd1:    msel = w_r.mag[1];
      default: msel = w_r.mag[2];
    endcase
    case (part_r)
      2'd0: begin
        opa = msel[HalfW-1:0];
        opb = msel[HalfW-1:0];
      end
      2'd1: begin
        opa = msel[HalfW-1:0];
        opb = HalfW'(msel[CrossW-1:HalfW]);
      end
      default: begin
        opa = HalfW'(msel[CrossW-1:HalfW]);
        opb = HalfW'(msel[CrossW-1:HalfW]);
      end
    endcase
  end

  always_comb begin
    case (shsel_r)
      2'd0:    addend = SumW'(prod_r);
      2'd1:    addend = SumW'(prod_r) << (HalfW + 1);
      default: addend = SumW'(prod_r) << (2 * HalfW);
    endcase
  end

  // Square root step: bring down two bits, try (root << 2) | 1.
  assign srem_nxt = {srem_r[RemW-3:0], sum_r[SumW-1 -: 2]};
  assign trial    = {root_r, 2'b01};

  // Sequencer and datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= StIdle;
      out_valid_r <= 1'b0;
      acc_en_r    <= 1'b0;
    end else begin
      // A word taken while a new one loads is replaced by the load below.
      if (out_valid_r && out_ready && st_r != StOut) out_valid_r <= 1'b0;
      case (st_r)
        StIdle: begin
          if (rd_valid) begin
            w_r      <= rd_word;
            k_r      <= '0;
            part_r   <= '0;
            acc_en_r <= 1'b0;
            sum_r    <= '0;
            st_r     <= rd_word.degen ? StOut : StSq;
          end
        end
        StSq: begin
          // The product is registered, so the first cycle of this state adds nothing.
          acc_en_r <= 1'b1;
          prod_r   <= opa * opb;
          shsel_r  <= part_r;
          if (acc_en_r) sum_r <= sum_r + addend;
          if (part_r == 2'd2) begin
            part_r <= '0;
            if (k_r == 2'd2) begin
              k_r <= 2'd3;
            end else begin
              k_r <= k_r + 1'b1;
            end
          end else begin
            part_r <= part_r + 1'b1;
          end
          if (k_r == 2'd3) begin
            srem_r <= '0;
            root_r <= '0;
            cnt_r  <= '0;
            st_r   <= StSqrt;
          end
        end
        StSqrt: begin
          sum_r <= sum_r << 2;
          if (srem_nxt >= trial) begin
            srem_r <= srem_nxt - trial;
            root_r <= {root_r[LenW-2:0], 1'b1};
          end else begin
            srem_r <= srem_nxt;
            root_r <= {root_r[LenW-2:0], 1'b0};
          end
          if (cnt_r == 7'(LenW - 1)) begin
            cnt_r <= '0;
            for (int k = 0; k < 3; k++) begin
              drem_r[k] <= RemW'(w_r.mag[k]);
              q_r[k]    <= '0;
            end
            st_r <= StDiv;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        StDiv: begin
          for (int k = 0; k < 3; k++) begin
            logic [RemW-1:0] t;
            t = (cnt_r == '0) ? drem_r[k] : (drem_r[k] << 1);
            if (t >= RemW'(root_r)) begin
              drem_r[k] <= t - RemW'(root_r);
              q_r[k]    <= {q_r[k][QuotW-2:0], 1'b1};
            end else begin
              drem_r[k] <= t;
              q_r[k]    <= {q_r[k][QuotW-2:0], 1'b0};
            end
          end
          if (cnt_r == 7'(QuotW - 1)) st_r <= StOut;
          else cnt_r <= cnt_r + 1'b1;
        end
        StOut: begin
          if (take_out) begin
            out_valid_r <= 1'b1;
            dg_r        <= w_r.degen;
            if (w_r.degen) begin
              nx_r <= '0;
              ny_r <= '0;
              nz_r <= OneQ30;
            end else begin
              nx_r <= w_r.neg[0] ? -OutW'(q_r[0]) : OutW'(q_r[0]);
              ny_r <= w_r.neg[1] ? -OutW'(q_r[1]) : OutW'(q_r[1]);
              nz_r <= w_r.neg[2] ? -OutW'(q_r[2]) : OutW'(q_r[2]);
            end
            st_r <= StIdle;
          end
        end
        default: st_r <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

### hw/rtl/triangle_unit_normal.sv
// Top level of the triangle unit normal block.
// Depends on tun_pkg, tun_front, tun_fifo and tun_back.
//
// Takes three signed Q16.16 vertices and returns the unit face normal in
// signed Q1.30, truncated toward zero, with a degenerate flag and (0,0,1)
// when the cross product is zero. The front pipeline accepts one word per
// cycle unless the four-word queue behind it is full and holds it; each word
// passes its edge, product and difference registers into that queue. The back
// part handles one word at a time: sum of squares from partial products,
// bit-serial square root, three parallel dividers, then the result register
// load; a degenerate word goes straight to the result register. That back
// loop sets the sustained rate.
`default_nettype none
module triangle_unit_normal
  import tun_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [CoordW-1:0] in_ax, in_ay, in_az,
  input  wire logic [CoordW-1:0] in_bx, in_by, in_bz,
  input  wire logic [CoordW-1:0] in_cx, in_cy, in_cz,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [OutW-1:0]        out_nx,
  output logic [OutW-1:0]        out_ny,
  output logic [OutW-1:0]        out_nz,
  output logic                   out_degenerate
);
  logic        push_valid, push_ready, rd_valid, rd_pop;
  cross_word_t push_word, rd_word;

  // Front: edges and cross product.
  tun_front u_front (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_ax, .in_ay, .in_az, .in_bx, .in_by, .in_bz, .in_cx, .in_cy, .in_cz,
    .push_valid, .push_ready, .push_word
  );

  // Queue between the two parts.
  tun_fifo u_fifo (
    .clk, .rst_n,
    .wr_valid (push_valid), .wr_ready (push_ready), .wr_word (push_word),
    .rd_valid, .rd_pop, .rd_word
  );

  // Back: length and normalization.
  tun_back u_back (
    .clk, .rst_n, .rd_valid, .rd_pop, .rd_word,
    .out_valid, .out_ready, .out_nx, .out_ny, .out_nz, .out_degenerate
  );
endmodule
`default_nettype wire

### verif/triangle_unit_normal_tb.sv
// Testbench for triangle_unit_normal: drives random and directed triangles and
// checks each unit normal word against a predictor built from wide integer math.
// Depends on tun_pkg and the triangle_unit_normal RTL.
`timescale 1ns / 100ps
module triangle_unit_normal_tb;
  import tun_pkg::*;

  localparam int CycleLimit = 2_000_000;

  typedef struct {
    logic [OutW-1:0] nx, ny, nz;
    logic            degenerate;
  } normal_t;

  typedef logic [CoordW-1:0] tri_t [9];

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CoordW-1:0] in_ax = '0, in_ay = '0, in_az = '0;
  logic [CoordW-1:0] in_bx = '0, in_by = '0, in_bz = '0;
  logic [CoordW-1:0] in_cx = '0, in_cy = '0, in_cz = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [OutW-1:0] out_nx, out_ny, out_nz;
  logic out_degenerate;

  normal_t pending_normals[$];
  int errors = 0;
  int cycles = 0;
  bit stall_free = 1'b0;

  triangle_unit_normal dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_ax(in_ax), .in_ay(in_ay), .in_az(in_az),
    .in_bx(in_bx), .in_by(in_by), .in_bz(in_bz),
    .in_cx(in_cx), .in_cy(in_cy), .in_cz(in_cz),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_nx(out_nx), .out_ny(out_ny), .out_nz(out_nz),
    .out_degenerate(out_degenerate)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Unit normal of one triangle, exact cross product and integer square root.
  function automatic normal_t face_normal(tri_t v);
    logic signed [33:0] e1 [3];
    logic signed [33:0] e2 [3];
    logic signed [69:0] cr [3];
    logic [69:0] mag [3];
    logic [159:0] sum_sq;
    logic [159:0] root, trial;
    logic [159:0] quo;
    logic [OutW-1:0] comp [3];
    normal_t n;
    for (int k = 0; k < 3; k++) begin
      e1[k] = {{2{v[3+k][31]}}, v[3+k]} - {{2{v[k][31]}}, v[k]};
      e2[k] = {{2{v[6+k][31]}}, v[6+k]} - {{2{v[k][31]}}, v[k]};
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0) begin
      n.nx = '0;
      n.ny = '0;
      n.nz = OneQ30;
      n.degenerate = 1'b1;
      return n;
    end
    sum_sq = '0;
    for (int k = 0; k < 3; k++) begin
      mag[k] = cr[k][69] ? 70'(-cr[k]) : 70'(cr[k]);
      sum_sq += 160'(mag[k]) * 160'(mag[k]);
    end
    // Bitwise square root, floor.
    root = '0;
    for (int b = 79; b >= 0; b--) begin
      trial = root | (160'(1) << b);
      if (trial * trial <= sum_sq) root = trial;
    end
    for (int k = 0; k < 3; k++) begin
      quo = (160'(mag[k]) << 30) / root;
      comp[k] = cr[k][69] ? OutW'(-quo[OutW-1:0]) : quo[OutW-1:0];
    end
    n.nx = comp[0];
    n.ny = comp[1];
    n.nz = comp[2];
    n.degenerate = 1'b0;
    return n;
  endfunction

  // Send one triangle after an optional idle gap; the expected normal is queued
  // at the edge where the word is taken.
  task automatic send_triangle(tri_t v, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_ax, in_ay, in_az} <= {v[0], v[1], v[2]};
    {in_bx, in_by, in_bz} <= {v[3], v[4], v[5]};
    {in_cx, in_cy, in_cz} <= {v[6], v[7], v[8]};
    forever begin
      @(negedge clk);
      if (in_ready) begin
        @(posedge clk);
        pending_normals.push_back(face_normal(v));
        break;
      end
    end
  endtask

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 250);
  endfunction

  function automatic logic [CoordW-1:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom();
    if (r < 8) return CoordW'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
    return CoordW'($signed($urandom_range(0, 200)) - 100);
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_normals.size() != 0) @(posedge clk);
  endtask

  // Axis aligned, mixed sign and extreme coordinate triangles.
  task automatic test_directed();
    tri_t v;
    logic [CoordW-1:0] mx, mn;
    mx = 32'h7fff_ffff;
    mn = 32'h8000_0000;
    v = '{0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0};
    send_triangle(v, 0);
    v = '{0, 0, 0, 0, 32'h10000, 0, 32'h10000, 0, 0};
    send_triangle(v, 0);
    v = '{0, 0, 0, 0, 0, 32'h10000, 32'h10000, 0, 0};
    send_triangle(v, 1);
    v = '{mx, mx, mx, mn, mn, mn, mn, mx, mn};
    send_triangle(v, 0);
    v = '{mn, mn, mn, mx, mn, mn, mn, mx, mn};
    send_triangle(v, 0);
    v = '{mx, mn, mx, mn, mx, mn, mx, mx, mn};
    send_triangle(v, 0);
    v = '{mn, mx, mn, mx, mn, mx, mn, mn, mx};
    send_triangle(v, 2);
    v = '{mx, mx, mx, mn, mx, mx, mx, mn, mx};
    send_triangle(v, 0);
    v = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
    send_triangle(v, 0);
    v = '{0, 0, 0, 1, 2, 3, 32'hffff_fffd, 7, 32'hffff_fffb};
    send_triangle(v, 0);
    v = '{32'hffff_ffff, 0, 0, 1, 0, 0, 0, 32'hffff_ffff, 32'hffff_ffff};
    send_triangle(v, 0);
    v = '{32'h0001_0000, 32'hfffe_0000, 32'h0003_8000, 32'hff00_0000, 32'h0012_3456,
          32'h7000_0000, 32'h0000_0001, 32'h9000_0000, 32'hffff_8000};
    send_triangle(v, 0);
  endtask

  // Coincident and collinear vertices, including at the extremes.
  task automatic test_degenerate();
    tri_t v;
    logic [CoordW-1:0] a [3];
    logic [CoordW-1:0] d [3];
    int k;
    v = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_triangle(v, 0);
    v = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
          32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
    send_triangle(v, 0);
    v = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0,
          32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    send_triangle(v, 0);
    v = '{1, 2, 3, 1, 2, 3, 5, 9, 11};
    send_triangle(v, 0);
    for (int i = 0; i < 6; i++) begin
      k = $urandom_range(1, 5);
      for (int j = 0; j < 3; j++) begin
        a[j] = CoordW'($signed($urandom_range(0, 2000)) - 1000);
        d[j] = CoordW'($signed($urandom_range(0, 200)) - 100);
        v[j] = a[j];
        v[3+j] = a[j] + d[j];
        v[6+j] = a[j] - CoordW'(k) * d[j];
      end
      send_triangle(v, idle_gap());
    end
  endtask

  // Random triangles: mostly general, some collinear, at random spacing.
  task automatic test_random(int count);
    tri_t v;
    logic [CoordW-1:0] d [3];
    int k;
    for (int i = 0; i < count; i++) begin
      for (int j = 0; j < 9; j++) v[j] = rand_coord();
      if ($urandom_range(0, 19) == 0) begin
        k = $urandom_range(0, 7) - 3;
        for (int j = 0; j < 3; j++) begin
          d[j] = CoordW'($signed($urandom_range(0, 60000)) - 30000);
          v[3+j] = v[j] + d[j];
          v[6+j] = v[j] + CoordW'(k) * d[j];
        end
      end
      send_triangle(v, idle_gap());
    end
  endtask

  // The sender holds off until every queued normal has come back.
  task automatic test_drain_pause();
    test_random(20);
    wait_drained();
    test_random(20);
  endtask

  // Result side stalls, with stretches of steady ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 299) == 0) stall_free <= ~stall_free;
      if (stall_free) out_ready <= 1'b1;
      else if ($urandom_range(0, 99) < 3) out_ready <= 1'b0;
      else if (!out_ready) out_ready <= ($urandom_range(0, 99) < 40);
      else out_ready <= ($urandom_range(0, 99) < 85);
    end
  end

  // Compare each delivered word with the oldest expected normal.
  always @(posedge clk) begin
    normal_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_normals.size() == 0) begin
        $display("%0t: unexpected word nx=%h ny=%h nz=%h degenerate=%b", $time,
                 out_nx, out_ny, out_nz, out_degenerate);
        errors++;
      end else begin
        want = pending_normals.pop_front();
        if (out_nx !== want.nx) begin
          $display("%0t: nx expected %h actual %h", $time, want.nx, out_nx);
          errors++;
        end
        if (out_ny !== want.ny) begin
          $display("%0t: ny expected %h actual %h", $time, want.ny, out_ny);
          errors++;
        end
        if (out_nz !== want.nz) begin
          $display("%0t: nz expected %h actual %h", $time, want.nz, out_nz);
          errors++;
        end
        if (out_degenerate !== want.degenerate) begin
          $display("%0t: degenerate expected %b actual %b", $time, want.degenerate,
                   out_degenerate);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_degenerate();
    test_drain_pause();
    test_random(600);
    wait_drained();
    repeat (300) @(posedge clk);
    if (errors == 0 && pending_normals.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

### sim.f
hw/rtl/tun_pkg.sv
hw/rtl/tun_front.sv
hw/rtl/tun_fifo.sv
hw/rtl/tun_back.sv
hw/rtl/triangle_unit_normal.sv
verif/triangle_unit_normal_tb.sv
